[rtl/can_rxq_pkg.sv]
// ----------------------------------------------------------------------------
// can_rxq_pkg
// Types and constants shared by the CAN frame receive queue.
// ----------------------------------------------------------------------------
package can_rxq_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = 3;
	localparam int ID_W        = 29;
	localparam int LEN_W       = 4;
	localparam int DATA_W      = 64;
	localparam int BYTES       = DATA_W / 8;

	localparam logic       KIND_PUSH = 1'b0;
	localparam logic       KIND_POP  = 1'b1;
	localparam logic [3:0] LEN_MAX   = 4'd8;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        sid_high;
		logic [7:0]        sid_low;
		logic [7:0]        eid_high;
		logic [7:0]        eid_low;
		logic [7:0]        dlc_byte;
		logic [DATA_W-1:0] rx_data;
	} rx_item_t;

	typedef struct packed {
		logic              valid_res;
		logic [ID_W-1:0]   frame_id;
		logic              is_extended;
		logic              is_remote;
		logic [LEN_W-1:0]  length;
		logic [DATA_W-1:0] payload;
		logic              dropped;
		logic [FILL_W-1:0] fill_count;
	} rx_result_t;

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             is_remote;
		logic             is_extended;
		logic [ID_W-1:0]  frame_id;
	} rx_header_t;

endpackage

[rtl/can_frame_receive_queue_core.sv]
// ----------------------------------------------------------------------------
// can_frame_receive_queue_core
// Receive queue for CAN frames: unpacks raw receive buffer images and holds
// them in a ring of QUEUE_DEPTH-1 frames.
//
// Usage: drive item and raise start; the word is taken at a rising edge with
// start high and busy low. busy stays low, so one word may follow another in
// every cycle. A push word unpacks identifier, flags and length (clamped to
// eight) and stores the frame, or drops it when the ring is full. A pop word
// returns the oldest frame with unused payload bytes cleared.
// Each word gives one result on result, marked by done for a single cycle,
// passing through one input register and then the result register that
// also holds the registered read of the frame store.
// Throughput is one word per cycle; pointers update at the input register
// stage so a following word sees them at once.
// Reset clears both pointers and the pipeline valid flags; the frame store
// is not cleared and is never read before it is written.
// The receiver cannot stall: each result must be taken in its cycle.
// ----------------------------------------------------------------------------
module can_frame_receive_queue_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  can_rxq_pkg::rx_item_t   item,
	output logic                    done,
	output can_rxq_pkg::rx_result_t result
);

	import can_rxq_pkg::*;

	rx_item_t   item_s1;
	logic       start_s1;
	ptr_t       wr_q, rd_q, wr_d, rd_d;
	logic       done_q;
	rx_result_t result_q;

	rx_header_t            header_mem [QUEUE_DEPTH];
	logic [DATA_W-1:0]     payload_mem [QUEUE_DEPTH];

	logic              is_push, is_pop, full, empty;
	rx_header_t        hdr;
	logic [DATA_W-1:0] pay;

	assign busy = 1'b0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
		end else begin
			start_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
	end

	// unpack
	always_comb begin
		hdr.is_extended = item_s1.sid_low[3];
		hdr.is_remote   = item_s1.dlc_byte[6];
		hdr.length      = (item_s1.dlc_byte[3:0] > LEN_MAX) ? LEN_MAX : item_s1.dlc_byte[3:0];
		if (item_s1.sid_low[3]) begin
			hdr.frame_id = {item_s1.sid_high, item_s1.sid_low[7:5], item_s1.sid_low[1:0],
				item_s1.eid_high, item_s1.eid_low};
		end else begin
			hdr.frame_id = {18'd0, item_s1.sid_high, item_s1.sid_low[7:5]};
		end
		for (int i = 0; i < BYTES; i++) begin
			pay[i*8 +: 8] = (i < int'(hdr.length)) ? item_s1.rx_data[i*8 +: 8] : 8'd0;
		end
	end

	assign is_push = start_s1 && (item_s1.kind == KIND_PUSH);
	assign is_pop  = start_s1 && (item_s1.kind == KIND_POP);
	assign full    = (ptr_t'(wr_q + 1'b1) == rd_q);
	assign empty   = (wr_q == rd_q);
	assign wr_d    = (is_push && !full) ? ptr_t'(wr_q + 1'b1) : wr_q;
	assign rd_d    = (is_pop && !empty) ? ptr_t'(rd_q + 1'b1) : rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			done_q <= 1'b0;
		end else begin
			wr_q   <= wr_d;
			rd_q   <= rd_d;
			done_q <= start_s1;
		end
	end

	// frame store
	always_ff @(posedge clk) begin
		if (is_push && !full) begin
			header_mem[wr_q]  <= hdr;
			payload_mem[wr_q] <= pay;
		end
	end

	// result register with registered store read
	always_ff @(posedge clk) begin
		rx_result_t res;
		res            = '0;
		res.fill_count = FILL_W'(ptr_t'(wr_d - rd_d));
		if (is_push) begin
			res.dropped = full;
		end else if (is_pop && !empty) begin
			res.valid_res   = 1'b1;
			res.frame_id    = header_mem[rd_q].frame_id;
			res.is_extended = header_mem[rd_q].is_extended;
			res.is_remote   = header_mem[rd_q].is_remote;
			res.length      = header_mem[rd_q].length;
			res.payload     = payload_mem[rd_q];
		end
		result_q <= res;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
